>>> rtl/tlc_pkg.sv
package tlc_pkg;

  localparam int N1 = 32;
  localparam int N2 = 128;
  localparam int N3 = 512;
  localparam int TAG_BITS = 32;
  localparam int LAT_BITS = 10;
  localparam int CNT_BITS = 32;
  localparam int CELLS = N1 + N2 + N3;
  localparam int NMAX = (N1 > N2) ? ((N1 > N3) ? N1 : N3) : ((N2 > N3) ? N2 : N3);
  localparam int FW = $clog2(NMAX + 1);

  // Hit level codes.
  localparam logic [1:0] LVL_FIRST  = 2'd0;
  localparam logic [1:0] LVL_SECOND = 2'd1;
  localparam logic [1:0] LVL_THIRD  = 2'd2;
  localparam logic [1:0] LVL_MEMORY = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_L1_LAT  = 2'd0;
  localparam logic [1:0] REG_L2_LAT  = 2'd1;
  localparam logic [1:0] REG_L3_LAT  = 2'd2;
  localparam logic [1:0] REG_MEM_LAT = 2'd3;

  typedef struct packed {
    logic cmp;
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Level that a cell of the flat chain belongs to.
  function automatic int lvl_of(input int i);
    int r;
    if (i < N1) begin
      r = 0;
    end else if (i < N1 + N2) begin
      r = 1;
    end else begin
      r = 2;
    end
    return r;
  endfunction

  // Position of a cell inside its level.
  function automatic int loc_of(input int i);
    int r;
    if (i < N1) begin
      r = i;
    end else if (i < N1 + N2) begin
      r = i - N1;
    end else begin
      r = i - N1 - N2;
    end
    return r;
  endfunction

  function automatic int level_size(input int l);
    int r;
    if (l == 0) begin
      r = N1;
    end else if (l == 1) begin
      r = N2;
    end else begin
      r = N3;
    end
    return r;
  endfunction

endpackage

>>> rtl/tlc_cell.sv
module tlc_cell
  import tlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic                valid,
  input  logic [TAG_BITS-1:0] key,
  input  logic [TAG_BITS-1:0] nbr_tag,
  input  logic [TAG_BITS-1:0] ins_tag,
  output logic [TAG_BITS-1:0] tag,
  output logic                match
);

  // Tag storage: a new tag wins over a shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tag <= ins_tag;
    end else if (ctrl.shift) begin
      tag <= nbr_tag;
    end
  end

  // Registered compare against the broadcast key.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.cmp) begin
      match <= valid && (tag == key);
    end
  end

endmodule

>>> rtl/three_level_exclusive_fifo_cache.sv
// Three exclusive, fully associative FIFO cache levels (32, 128 and 512 entries) held
// as one row of tag cells. Each transfer on the input stream is one block tag; one
// result comes back per tag with the serving level, its configured latency and the
// running memory fetch count. After acceptance the sequencer steps through MATCH to
// compare in all cells, REMOVE to resolve the hit and close the gap in the hit level,
// INS1, INS2 and INS3 for the insert and eviction cascade, one per level and skipped
// on a first level hit, and DONE to load the result register once the output register
// is free. The input is ready again in the cycle after that load. A new tag is taken
// while a result still waits; the next result then waits until the output register has
// been emptied.
module three_level_exclusive_fifo_cache
  import tlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] block_tag
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [1:0] hit_level, [11:2] access_latency,
                                              // [43:12] fetch_count, [47:44] zero
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [LAT_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_REMOVE, S_INS1, S_INS2, S_INS3, S_DONE
  } state_t;

  state_t               state;
  logic [TAG_BITS-1:0]  key;
  logic [TAG_BITS-1:0]  vic;
  logic                 evict;
  logic [FW-1:0]        fill [3];
  logic [CNT_BITS-1:0]  fetches;
  logic [1:0]           res_lvl;
  logic [LAT_BITS-1:0]  res_lat;
  logic [LAT_BITS-1:0]  lat1, lat2, lat3, latm;

  logic [TAG_BITS-1:0]  tag [CELLS];
  logic [TAG_BITS-1:0]  nbr [CELLS];
  logic [TAG_BITS-1:0]  ins_tag;
  logic [CELLS-1:0]     match;
  logic [CELLS-1:0]     pre;
  logic [CELLS-1:0]     valid;
  cell_ctrl_t           ctrl [CELLS];
  logic [2:0]           full;
  logic [2:0]           ap_on;
  logic [1:0]           hit_lvl;

  assign s_axis_tready = (state == S_IDLE);

  // Per-level status.
  assign full[0] = (fill[0] == FW'(N1));
  assign full[1] = (fill[1] == FW'(N2));
  assign full[2] = (fill[2] == FW'(N3));
  assign ap_on[0] = (state == S_INS1);
  assign ap_on[1] = (state == S_INS2) && evict;
  assign ap_on[2] = (state == S_INS3) && evict;
  assign ins_tag = (state == S_INS1) ? key : vic;

  // The last prefix bit of each level tells whether that level holds the key.
  always_comb begin
    if (pre[N1-1]) begin
      hit_lvl = LVL_FIRST;
    end else if (pre[N1+N2-1]) begin
      hit_lvl = LVL_SECOND;
    end else if (pre[CELLS-1]) begin
      hit_lvl = LVL_THIRD;
    end else begin
      hit_lvl = LVL_MEMORY;
    end
  end

  // The row of cells with its per-cell control.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int L   = lvl_of(i);
    localparam int LOC = loc_of(i);
    localparam int LN  = level_size(L);

    assign valid[i] = FW'(LOC) < fill[L];

    if (LOC == 0) begin : g_head
      assign pre[i] = match[i];
    end else begin : g_body
      assign pre[i] = match[i] | pre[i-1];
    end

    if (LOC == LN - 1) begin : g_tail
      assign nbr[i] = tag[i];
    end else begin : g_mid
      assign nbr[i] = tag[i+1];
    end

    assign ctrl[i].cmp   = (state == S_MATCH);
    assign ctrl[i].shift = ((state == S_REMOVE) && (L != 0) && (hit_lvl == 2'(L)) && pre[i])
                           || (ap_on[L] && full[L]);
    assign ctrl[i].load  = ap_on[L] && (full[L] ? (LOC == LN - 1) : (FW'(LOC) == fill[L]));

    tlc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[i]),
      .valid   (valid[i]),
      .key     (key),
      .nbr_tag (nbr[i]),
      .ins_tag (ins_tag),
      .tag     (tag[i]),
      .match   (match[i])
    );
  end

  // Latency registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lat1 <= LAT_BITS'(4);
      lat2 <= LAT_BITS'(12);
      lat3 <= LAT_BITS'(40);
      latm <= LAT_BITS'(200);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_L1_LAT:  lat1 <= cfg_data;
        REG_L2_LAT:  lat2 <= cfg_data;
        REG_L3_LAT:  lat3 <= cfg_data;
        REG_MEM_LAT: latm <= cfg_data;
        default: ;
      endcase
    end
  end

  // Access sequencer, fill counts and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      evict         <= 1'b0;
      fill[0]       <= '0;
      fill[1]       <= '0;
      fill[2]       <= '0;
      fetches       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            key   <= s_axis_tdata[TAG_BITS-1:0];
            state <= S_MATCH;
          end
        end
        S_MATCH: state <= S_REMOVE;
        S_REMOVE: begin
          res_lvl <= hit_lvl;
          case (hit_lvl)
            LVL_FIRST:  res_lat <= lat1;
            LVL_SECOND: begin
              res_lat <= lat2;
              fill[1] <= fill[1] - FW'(1);
            end
            LVL_THIRD: begin
              res_lat <= lat3;
              fill[2] <= fill[2] - FW'(1);
            end
            default: begin
              res_lat <= latm;
              fetches <= fetches + CNT_BITS'(1);
            end
          endcase
          state <= (hit_lvl == LVL_FIRST) ? S_DONE : S_INS1;
        end
        S_INS1: begin
          evict <= full[0];
          vic   <= tag[0];
          if (!full[0]) begin
            fill[0] <= fill[0] + FW'(1);
          end
          state <= S_INS2;
        end
        S_INS2: begin
          if (evict) begin
            evict <= full[1];
            vic   <= tag[N1];
            if (!full[1]) begin
              fill[1] <= fill[1] + FW'(1);
            end
          end
          state <= S_INS3;
        end
        S_INS3: begin
          if (evict && !full[2]) begin
            fill[2] <= fill[2] + FW'(1);
          end
          evict <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0, fetches, res_lat, res_lvl};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Levels stay disjoint, so one key matches at most one cell.
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE) |-> $onehot0(match))
    else $error("key matched more than one cell");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= FW'(N1)) && (fill[1] <= FW'(N2)) && (fill[2] <= FW'(N3)))
    else $error("level fill count above capacity");

  a_fetch_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE && hit_lvl != LVL_MEMORY) |=> $stable(fetches))
    else $error("fetch count moved on a cache hit");

  a_accept_go: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == S_MATCH))
    else $error("accepted tag did not start a lookup");

endmodule
